>>> rtl/core/vrr_pkg.sv
// ----------------------------------------------------------------------------
// vrr_pkg
// Shared types for the vcpu round-robin scheduler: life-cycle states,
// request kinds, sequencer states and the ready-queue control bundles.
// ----------------------------------------------------------------------------
package vrr_pkg;

  typedef enum logic [2:0] {
    LIFE_OFFLINE   = 3'd0,
    LIFE_READY     = 3'd1,
    LIFE_RUNNING   = 3'd2,
    LIFE_SUSPENDED = 3'd3,
    LIFE_HALTED    = 3'd4
  } life_t;

  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_SUSPEND = 3'd1,
    KIND_RESUME  = 3'd2,
    KIND_HALT    = 3'd3,
    KIND_SWITCH  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_SW_CHECK,
    SEQ_SW_POP
  } seq_state_t;

  // ready-queue commands from the sequencer
  typedef struct packed {
    logic push;    // write push data at tail, advance tail (dropped when full)
    logic pop_rd;  // read the entry at head
    logic pop;     // advance head
  } fifo_ctl_t;

  // ready-queue status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

>>> rtl/core/vcpu_round_robin_scheduler_core.sv
// ----------------------------------------------------------------------------
// vcpu_round_robin_scheduler_core
// Sequencing: start/suspend/resume/halt read the life state, then load the
//   output register from SEQ_EXEC; a switch loads it from SEQ_SW_CHECK when
//   it goes idle, else from SEQ_SW_POP. A new request is taken only in
//   SEQ_IDLE, after the read-then-write pass over the state and queue memories.
// Reset: clears the life-state valid bits (all vcpus offline), the queue
//   pointers and the current slot at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vcpu_round_robin_scheduler_core #(
  parameter int NUM_VCPUS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_kind,
  input  logic [3:0] in_vcpu_index,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_applied,
  output logic [2:0] out_target_state,
  output logic       out_running_valid,
  output logic [3:0] out_running_index
);

  localparam int IDX_W = (NUM_VCPUS > 1) ? $clog2(NUM_VCPUS) : 1;

  // --------------------------------------------------------------------------
  // Sequencer and request registers
  // --------------------------------------------------------------------------
  vrr_pkg::seq_state_t seq_r, seq_nxt;
  vrr_pkg::kind_t      kind_r;
  logic [IDX_W-1:0]    idx_r;
  logic                idx_ok_r;     // named vcpu exists
  logic                fwd_r;        // switch pops the entry it just pushed

  // current (running) slot
  logic                cur_present_r, cur_present_nxt;
  logic [IDX_W-1:0]    cur_idx_r, cur_idx_nxt;

  // output register
  logic                out_valid_r;
  logic                out_applied_r;
  vrr_pkg::life_t      out_tstate_r;
  logic                out_run_vld_r;
  logic [IDX_W-1:0]    out_run_idx_r;

  logic                res_load;     // load the output register this cycle
  logic                res_applied;
  vrr_pkg::life_t      res_tstate;

  logic                out_free;     // output register can take a result
  logic                accept;

  // memory ports
  logic                st_rd_en;
  logic [IDX_W-1:0]    st_rd_addr;
  vrr_pkg::life_t      st_rd_data;
  logic                st_wr_en;
  logic [IDX_W-1:0]    st_wr_addr;
  vrr_pkg::life_t      st_wr_data;

  vrr_pkg::fifo_ctl_t  fq_ctl;
  logic [IDX_W-1:0]    fq_push_data;
  logic [IDX_W-1:0]    fq_rd_data;
  vrr_pkg::fifo_sts_t  fq_sts;

  logic                requeue;      // switch finds current vcpu still running
  logic [IDX_W-1:0]    next_idx;     // vcpu picked by a popping switch

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (seq_r == vrr_pkg::SEQ_IDLE);
  assign accept   = in_valid && in_ready;

  assign requeue  = cur_present_r && (st_rd_data == vrr_pkg::LIFE_RUNNING);
  assign next_idx = fwd_r ? cur_idx_r : fq_rd_data;

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      vrr_pkg::SEQ_IDLE: begin
        if (accept) begin
          seq_nxt = (vrr_pkg::kind_t'(in_kind) == vrr_pkg::KIND_SWITCH) ?
                    vrr_pkg::SEQ_SW_CHECK : vrr_pkg::SEQ_EXEC;
        end
      end
      vrr_pkg::SEQ_EXEC: begin
        if (out_free) begin
          seq_nxt = vrr_pkg::SEQ_IDLE;
        end
      end
      vrr_pkg::SEQ_SW_CHECK: begin
        // queue stays empty: go idle with a result, else pop in SEQ_SW_POP
        if (fq_sts.empty && !requeue) begin
          if (out_free) begin
            seq_nxt = vrr_pkg::SEQ_IDLE;
          end
        end else begin
          seq_nxt = vrr_pkg::SEQ_SW_POP;
        end
      end
      vrr_pkg::SEQ_SW_POP: begin
        if (out_free) begin
          seq_nxt = vrr_pkg::SEQ_IDLE;
        end
      end
      default: seq_nxt = vrr_pkg::SEQ_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output and datapath logic: memory commands, current slot, result
  // --------------------------------------------------------------------------
  always_comb begin
    st_rd_en        = 1'b0;
    st_rd_addr      = cur_idx_r;
    st_wr_en        = 1'b0;
    st_wr_addr      = idx_r;
    st_wr_data      = vrr_pkg::LIFE_OFFLINE;
    fq_ctl          = '0;
    fq_push_data    = idx_r;
    cur_present_nxt = cur_present_r;
    cur_idx_nxt     = cur_idx_r;
    res_load        = 1'b0;
    res_applied     = 1'b0;
    res_tstate      = vrr_pkg::LIFE_OFFLINE;

    unique case (seq_r)
      vrr_pkg::SEQ_IDLE: begin
        // read the named vcpu, or the current one for a switch
        st_rd_en = accept;
        if (vrr_pkg::kind_t'(in_kind) != vrr_pkg::KIND_SWITCH) begin
          st_rd_addr = IDX_W'(in_vcpu_index);
        end
      end

      vrr_pkg::SEQ_EXEC: begin
        if (out_free) begin
          res_load = 1'b1;
          if (idx_ok_r) begin
            res_tstate = st_rd_data;
            unique case (kind_r)
              vrr_pkg::KIND_START: begin
                if (st_rd_data == vrr_pkg::LIFE_OFFLINE) begin
                  res_tstate  = vrr_pkg::LIFE_READY;
                  fq_ctl.push = 1'b1;
                end
              end
              vrr_pkg::KIND_SUSPEND: begin
                if (st_rd_data == vrr_pkg::LIFE_RUNNING) begin
                  res_tstate = vrr_pkg::LIFE_SUSPENDED;
                end
              end
              vrr_pkg::KIND_RESUME: begin
                if (st_rd_data == vrr_pkg::LIFE_SUSPENDED) begin
                  res_tstate  = vrr_pkg::LIFE_READY;
                  fq_ctl.push = 1'b1;
                end
              end
              vrr_pkg::KIND_HALT: begin
                if (st_rd_data == vrr_pkg::LIFE_RUNNING) begin
                  res_tstate = vrr_pkg::LIFE_HALTED;
                end
              end
              default: ;  // unknown kind: report state, change nothing
            endcase
            res_applied = (res_tstate != st_rd_data);
            st_wr_en    = res_applied;
            st_wr_data  = res_tstate;
          end
        end
      end

      vrr_pkg::SEQ_SW_CHECK: begin
        if (fq_sts.empty && !requeue) begin
          // nothing to run: drop the current slot
          if (out_free) begin
            res_load        = 1'b1;
            res_applied     = cur_present_r;
            cur_present_nxt = 1'b0;
            cur_idx_nxt     = '0;
          end
        end else begin
          // requeue a still-running current vcpu, read the queue head
          st_wr_en     = requeue;
          st_wr_addr   = cur_idx_r;
          st_wr_data   = vrr_pkg::LIFE_READY;
          fq_ctl.push  = requeue;
          fq_push_data = cur_idx_r;
          fq_ctl.pop_rd = !fq_sts.empty;
        end
      end

      vrr_pkg::SEQ_SW_POP: begin
        if (out_free) begin
          fq_ctl.pop      = 1'b1;
          st_wr_en        = 1'b1;
          st_wr_addr      = next_idx;
          st_wr_data      = vrr_pkg::LIFE_RUNNING;
          cur_present_nxt = 1'b1;
          cur_idx_nxt     = next_idx;
          res_load        = 1'b1;
          res_applied     = 1'b1;
          res_tstate      = vrr_pkg::LIFE_RUNNING;
        end
      end

      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r         <= vrr_pkg::SEQ_IDLE;
      cur_present_r <= 1'b0;
      cur_idx_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      seq_r         <= seq_nxt;
      cur_present_r <= cur_present_nxt;
      cur_idx_r     <= cur_idx_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= vrr_pkg::kind_t'(in_kind);
      idx_r    <= IDX_W'(in_vcpu_index);
      idx_ok_r <= (32'(in_vcpu_index) < 32'(NUM_VCPUS));
    end
    if (seq_r == vrr_pkg::SEQ_SW_CHECK) begin
      // queue was empty, so the head is the vcpu pushed this cycle
      fwd_r <= fq_sts.empty;
    end
    if (res_load) begin
      out_applied_r <= res_applied;
      out_tstate_r  <= res_tstate;
      out_run_vld_r <= cur_present_nxt;
      out_run_idx_r <= cur_present_nxt ? cur_idx_nxt : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  vrr_state_mem #(
    .NUM_VCPUS (NUM_VCPUS)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  vrr_ready_fifo #(
    .NUM_VCPUS (NUM_VCPUS)
  ) u_ready_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fq_ctl),
    .push_data (fq_push_data),
    .rd_data   (fq_rd_data),
    .sts       (fq_sts)
  );

  assign out_valid         = out_valid_r;
  assign out_applied       = out_applied_r;
  assign out_target_state  = out_tstate_r;
  assign out_running_valid = out_run_vld_r;
  assign out_running_index = 4'(out_run_idx_r);

endmodule

>>> rtl/core/vrr_state_mem.sv
// ----------------------------------------------------------------------------
// vrr_state_mem
// Life-cycle state store: one synchronous memory entry per vcpu with a
// registered read port. Per-entry valid bits make unwritten entries read
// as offline right after reset.
// ----------------------------------------------------------------------------
module vrr_state_mem #(
  parameter int NUM_VCPUS = 16,
  localparam int IDX_W = (NUM_VCPUS > 1) ? $clog2(NUM_VCPUS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output vrr_pkg::life_t     rd_data,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  vrr_pkg::life_t     wr_data
);

  vrr_pkg::life_t          mem [NUM_VCPUS];
  logic [NUM_VCPUS-1:0]    vld_r;
  vrr_pkg::life_t          rd_q_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // unwritten entry reads as offline
  assign rd_data = rd_vld_r ? rd_q_r : vrr_pkg::LIFE_OFFLINE;

endmodule

>>> rtl/core/vrr_ready_fifo.sv
// ----------------------------------------------------------------------------
// vrr_ready_fifo
// Ready queue of vcpu indices: a synchronous memory with head, tail and
// count registers. Head read data is registered; push when full is dropped.
// ----------------------------------------------------------------------------
module vrr_ready_fifo #(
  parameter int NUM_VCPUS = 16,
  localparam int IDX_W = (NUM_VCPUS > 1) ? $clog2(NUM_VCPUS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vrr_pkg::fifo_ctl_t ctl,
  input  logic [IDX_W-1:0]   push_data,
  output logic [IDX_W-1:0]   rd_data,
  output vrr_pkg::fifo_sts_t sts
);

  localparam int CNT_W = $clog2(NUM_VCPUS + 1);

  logic [IDX_W-1:0] mem [NUM_VCPUS];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rd_q_r;
  logic             do_push;

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNT_W'(NUM_VCPUS));
  assign do_push   = ctl.push && !sts.full;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == IDX_W'(NUM_VCPUS - 1)) ? '0 : tail_r + 1'b1;
    end
    if (ctl.pop) begin
      head_nxt = (head_r == IDX_W'(NUM_VCPUS - 1)) ? '0 : head_r + 1'b1;
    end
    if (do_push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= push_data;
    end
    if (ctl.pop_rd) begin
      rd_q_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign rd_data = rd_q_r;

endmodule

>>> verif/vcpu_round_robin_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// vcpu_round_robin_scheduler_core_tb
// Self-checking bench for the vcpu round-robin scheduler. A request queue
// feeds a falling-edge driver; a rising-edge monitor predicts every accepted
// request against a private copy of the vcpu life states, the ready queue
// and the current slot, and compares each result in order.
// ----------------------------------------------------------------------------
module vcpu_round_robin_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vrr_pkg::*;

  localparam int VCPU_COUNT = 16;
  localparam int IDLE_LIMIT = 1000;     // cycles with no handshake at all
  localparam int LONG_HOLD = 120;       // receiver back-pressure stretch
  localparam int RANDOM_REQUESTS = 1425;
  localparam int HALT_BUDGET = 8;       // halted is terminal; keep vcpus alive

  // kinds the block must treat as unknown
  localparam logic [2:0] KIND_BAD_FIRST = 3'd5;
  localparam logic [2:0] KIND_BAD_LAST = 3'd7;

  typedef struct {
    logic [2:0] kind;
    logic [3:0] vcpu;
    int unsigned gap;
  } sched_request_t;

  typedef struct packed {
    logic       applied;
    life_t      tstate;
    logic       run_valid;
    logic [3:0] run_index;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_kind = KIND_SWITCH;
  logic [3:0] in_vcpu_index = 4'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_applied;
  logic [2:0] out_target_state;
  logic       out_running_valid;
  logic [3:0] out_running_index;

  vcpu_round_robin_scheduler_core #(
    .NUM_VCPUS(VCPU_COUNT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_vcpu_index    (in_vcpu_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_applied      (out_applied),
    .out_target_state (out_target_state),
    .out_running_valid(out_running_valid),
    .out_running_index(out_running_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scheduler shadow: life states, ready queue and current slot.
  // --------------------------------------------------------------------------
  life_t      vcpu_life [VCPU_COUNT];
  logic [3:0] ready_order [$];
  logic       cur_present = 1'b0;
  logic [3:0] cur_index = 4'd0;

  sched_request_t request_queue [$];
  sched_result_t  pending_outcomes [$];

  int unsigned error_count = 0;
  logic        req_taken = 1'b0;
  logic        res_taken = 1'b0;
  int unsigned idle_cycles = 0;

  // Idling controls shared by both sides.
  logic        steady = 1'b0;        // no gaps and no stalls while set
  int unsigned long_hold_asks = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned recv_wait = 0;
  int unsigned send_wait = 0;
  logic        staged = 1'b0;
  sched_request_t next_req;

  // Drop the push if the queue is full; the state change still stands.
  function automatic void enqueue_ready(logic [3:0] v);
    if (ready_order.size() < VCPU_COUNT) ready_order.push_back(v);
  endfunction

  // Apply one request to the shadow and return the result it must produce.
  function automatic sched_result_t schedule_request(logic [2:0] kind, logic [3:0] idx);
    sched_result_t r;
    logic was_present;
    r.applied = 1'b0;
    r.tstate = LIFE_OFFLINE;
    if (kind == KIND_SWITCH) begin
      was_present = cur_present;
      // Requeue the current vcpu only if it is still running; a suspended
      // or halted current vcpu simply loses its slot.
      if (cur_present && vcpu_life[cur_index] == LIFE_RUNNING) begin
        vcpu_life[cur_index] = LIFE_READY;
        enqueue_ready(cur_index);
      end
      if (ready_order.size() == 0) begin
        cur_present = 1'b0;
        cur_index = 4'd0;
      end else begin
        cur_index = ready_order.pop_front();
        vcpu_life[cur_index] = LIFE_RUNNING;
        cur_present = 1'b1;
      end
      r.applied = was_present || cur_present;
      r.tstate = cur_present ? vcpu_life[cur_index] : LIFE_OFFLINE;
    end else if (idx < VCPU_COUNT) begin
      case (kind)
        KIND_START: begin
          if (vcpu_life[idx] == LIFE_OFFLINE) begin
            vcpu_life[idx] = LIFE_READY;
            enqueue_ready(idx);
            r.applied = 1'b1;
          end
        end
        KIND_SUSPEND: begin
          if (vcpu_life[idx] == LIFE_RUNNING) begin
            vcpu_life[idx] = LIFE_SUSPENDED;
            r.applied = 1'b1;
          end
        end
        KIND_RESUME: begin
          if (vcpu_life[idx] == LIFE_SUSPENDED) begin
            vcpu_life[idx] = LIFE_READY;
            enqueue_ready(idx);
            r.applied = 1'b1;
          end
        end
        KIND_HALT: begin
          if (vcpu_life[idx] == LIFE_RUNNING) begin
            vcpu_life[idx] = LIFE_HALTED;
            r.applied = 1'b1;
          end
        end
        default: ;  // unknown kind: no change, report the named vcpu
      endcase
      r.tstate = vcpu_life[idx];
    end
    r.run_valid = cur_present;
    r.run_index = cur_present ? cur_index : 4'd0;
    return r;
  endfunction

  // Return some vcpu in the given state, or -1 if none, starting the scan at a random spot.
  function automatic int find_vcpu(life_t s);
    int base;
    int j;
    base = $urandom_range(0, VCPU_COUNT - 1);
    for (j = 0; j < VCPU_COUNT; j++) begin
      if (vcpu_life[(base + j) % VCPU_COUNT] == s) return (base + j) % VCPU_COUNT;
    end
    return -1;
  endfunction

  task automatic add_request(logic [2:0] kind, logic [3:0] vcpu);
    sched_request_t q;
    q.kind = kind;
    q.vcpu = vcpu;
    q.gap = steady ? 0 : $urandom_range(0, 3);
    request_queue.push_back(q);
  endtask

  task automatic note_error(string msg);
    if (error_count < 10) $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: stage the next request, hold off its gap, then hold valid
  // and payload until accepted.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (!staged && request_queue.size() != 0) begin
        next_req = request_queue.pop_front();
        staged = 1'b1;
        send_wait = next_req.gap;
      end
      if (staged && send_wait == 0) begin
        in_valid <= 1'b1;
        in_kind <= next_req.kind;
        in_vcpu_index <= next_req.vcpu;
        staged = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (staged) send_wait--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: draw a stall after every result; serve long holds on request.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (holds_served != long_hold_asks) begin
        hold_left = LONG_HOLD;
        holds_served = long_hold_asks;
      end
      if (res_taken) recv_wait = steady ? 0 : $urandom_range(0, 3);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results against the oldest prediction, predict each
  // accepted request, and watch for a stuck handshake.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    req_taken = rst_n && in_valid && in_ready;
    res_taken = rst_n && out_valid && out_ready;
    if (res_taken) begin
      if (pending_outcomes.size() == 0) begin
        note_error($sformatf("result with no request pending: applied=%0d state=%0d run=%0d/%0d",
                             out_applied, out_target_state, out_running_valid,
                             out_running_index));
      end else begin
        sched_result_t want;
        want = pending_outcomes.pop_front();
        if (out_applied !== want.applied || out_target_state !== want.tstate ||
            out_running_valid !== want.run_valid || out_running_index !== want.run_index)
          note_error($sformatf({"mismatch: exp applied=%0d state=%0d run=%0d/%0d, ",
                                "got applied=%0d state=%0d run=%0d/%0d"},
                               want.applied, want.tstate, want.run_valid, want.run_index,
                               out_applied, out_target_state, out_running_valid,
                               out_running_index));
      end
    end
    if (req_taken) pending_outcomes.push_back(schedule_request(in_kind, in_vcpu_index));

    if (!rst_n || req_taken || res_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int n;
    int pick;
    int target;
    int halted;
    logic [2:0] k;
    logic [3:0] v;

    foreach (vcpu_life[i]) vcpu_life[i] = LIFE_OFFLINE;

    // Directed: refused guards, switch while idle and going idle, current
    // vcpu suspended or halted before a switch, unknown kinds.
    add_request(KIND_SWITCH, 4'd0);     // idle stays idle
    add_request(KIND_SUSPEND, 4'd3);    // offline: refused
    add_request(KIND_START, 4'd0);
    add_request(KIND_START, 4'd15);
    add_request(KIND_START, 4'd0);      // already ready: refused
    add_request(KIND_HALT, 4'd15);      // ready: refused
    add_request(KIND_SWITCH, 4'd9);     // pop vcpu 0
    add_request(KIND_SUSPEND, 4'd0);    // current suspended, keeps its slot
    add_request(KIND_SWITCH, 4'd0);     // no requeue, pop vcpu 15
    add_request(KIND_RESUME, 4'd15);    // running: refused
    add_request(KIND_HALT, 4'd15);      // current halted
    add_request(KIND_SWITCH, 4'd15);    // queue empty: go idle
    add_request(KIND_SWITCH, 4'd15);    // idle stays idle
    add_request(KIND_RESUME, 4'd0);
    add_request(KIND_RESUME, 4'd0);     // ready: refused
    add_request(KIND_START, 4'd7);
    add_request(KIND_SWITCH, 4'd0);     // pop vcpu 0
    add_request(KIND_SWITCH, 4'd0);     // requeue 0, pop 7
    add_request(KIND_SUSPEND, 4'd7);
    add_request(KIND_RESUME, 4'd7);     // current back in the queue as ready
    add_request(KIND_SWITCH, 4'd0);     // current is ready, not requeued
    add_request(KIND_BAD_FIRST, 4'd15);
    add_request(KIND_BAD_FIRST + 3'd1, 4'd0);
    add_request(KIND_BAD_LAST, 4'd7);
    add_request(KIND_HALT, 4'd3);       // offline: refused

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      // Ask for one long receiver hold while requests keep coming.
      if (n == 300) long_hold_asks++;
      // Pause the sender once until every result is back.
      if (n == 700) begin
        while (request_queue.size() != 0 || staged || in_valid || pending_outcomes.size() != 0)
          @(negedge clk);
      end
      steady = (n >= 1000 && n < 1100);
      while (request_queue.size() >= 4) @(negedge clk);

      // Shape from the (slightly stale) shadow: mostly well-formed
      // life-cycle traffic, the rest noise over every kind and index.
      halted = 0;
      foreach (vcpu_life[i]) if (vcpu_life[i] == LIFE_HALTED) halted++;
      pick = $urandom_range(0, 99);
      k = KIND_SWITCH;
      v = 4'($urandom_range(0, VCPU_COUNT - 1));
      if (pick < 25) begin
        k = 3'($urandom_range(0, 7));
      end else if (pick < 55) begin
        k = KIND_SWITCH;
      end else if (pick < 70) begin
        target = find_vcpu(LIFE_SUSPENDED);
        if (target < 0) begin
          target = find_vcpu(LIFE_OFFLINE);
          if (target >= 0) k = KIND_START;
        end else begin
          k = KIND_RESUME;
        end
        if (target >= 0) v = 4'(target);
      end else if (pick < 78) begin
        target = find_vcpu(LIFE_OFFLINE);
        if (target >= 0) begin
          k = KIND_START;
          v = 4'(target);
        end
      end else if (pick < 94) begin
        if (cur_present) begin
          k = KIND_SUSPEND;
          v = cur_index;
        end
      end else if (pick < 97) begin
        if (cur_present && halted < HALT_BUDGET) begin
          k = KIND_HALT;
          v = cur_index;
        end
      end else begin
        // Suspend or halt of an arbitrary vcpu: mostly refused.
        k = ($urandom_range(0, 1) != 0) ? KIND_SUSPEND : KIND_HALT;
      end
      add_request(k, v);
    end
    steady = 1'b0;

    // Drain, then keep the clock running so that any stray result still shows.
    while (request_queue.size() != 0 || staged || in_valid || pending_outcomes.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);

    if (error_count == 0 && pending_outcomes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
